// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

// File: rtl/core/trt_pkg.sv
package trt_pkg;

  localparam int unsigned RES_BITS_DEF   = 24;
  localparam int unsigned COEF_FRAC_DEF  = 56;
  localparam int unsigned COEF_W         = 48;
  localparam int unsigned COEF_H         = 24;
  localparam int unsigned UL_W           = 9;
  localparam int unsigned TEMP_W         = 18;
  localparam int unsigned STAT_W         = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned FRAC_BITS      = 24;
  localparam int unsigned SUM_W          = 66;
  localparam int unsigned DIV_W          = 64;
  localparam int unsigned Q_W            = 62;
  localparam int unsigned Y_W            = 20;
  localparam int unsigned RECIP_W        = 21;
  localparam int unsigned DIV_SHIFT      = 23;
  localparam logic [31:0] LN2_Q32        = 32'd2977044472;
  localparam int unsigned KELVIN_OFS     = 1398528;
  localparam int unsigned STEPS_PER_C    = 5120;
  localparam int unsigned LOW_LIMIT_C    = 50;
  // ceil(2^23 / 5): exact division by five for values below 2^20.
  localparam int unsigned DIV5_RECIP     = 1677722;

  localparam logic signed [COEF_W-1:0] COEF_A_RST = 48'sd81065000000000;
  localparam logic signed [COEF_W-1:0] COEF_B_RST = 48'sd16912000000000;
  localparam logic signed [COEF_W-1:0] COEF_C_RST = 48'sd6172500000;
  localparam logic [UL_W-1:0]          UPPER_RST  = 9'd250;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A = 2'd0,
    CFG_COEF_B = 2'd1,
    CFG_COEF_C = 2'd2,
    CFG_UPPER  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic res_zero;
  } lane_ctl_t;

endpackage

// File: rtl/core/trt_if.sv
interface trt_in_if import trt_pkg::*; #(
  parameter int unsigned RES_BITS = RES_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [RES_BITS-1:0] resistance_ohms;

  modport source (output valid, output resistance_ohms, input ready);
  modport sink   (input valid, input resistance_ohms, output ready);
endinterface

interface trt_out_if import trt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_q8;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output temp_q8, output status, input ready);
  modport sink   (input valid, input temp_q8, input status, output ready);
endinterface

// File: rtl/core/trt_log.sv
module trt_log import trt_pkg::*; #(
  parameter int unsigned RES_BITS = RES_BITS_DEF,
  localparam int unsigned PW      = $clog2(RES_BITS),
  localparam int unsigned L_W     = PW + FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RES_BITS-1:0] r_i,
  output lane_ctl_t           ctl_o,
  output logic [L_W-1:0]      l_o
);

  logic [PW-1:0]       p_enc;
  logic                va_q;
  logic                za_q;
  logic [RES_BITS-1:0] ra_q;
  logic [PW-1:0]       pa_q;

  logic                v_q    [0:FRAC_BITS];
  logic                z_q    [0:FRAC_BITS];
  logic [31:0]         m_q    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] f_q   [0:FRAC_BITS];
  logic [PW-1:0]       p_q    [0:FRAC_BITS];

  logic [L_W+31:0]     ln_prod;
  logic                vl_q;
  logic                zl_q;
  logic [L_W-1:0]      l_q;

  // Leading-one position; the highest set bit wins.
  always_comb begin
    p_enc = '0;
    for (int k = 0; k < RES_BITS; k++) begin
      if (r_i[k]) p_enc = PW'(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      za_q <= (r_i == '0);
      ra_q <= r_i;
      pa_q <= p_enc;
    end
  end

  // Normalize the mantissa to Q1.31.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= za_q;
      m_q[0] <= 32'(ra_q) << (5'd31 - 5'(pa_q));
      f_q[0] <= '0;
      p_q[0] <= pa_q;
    end
  end

  // One fraction bit of log2 per stage by repeated squaring.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(m_q[k]) * 64'(m_q[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[k+1] <= z_q[k];
        p_q[k+1] <= p_q[k];
        f_q[k+1] <= {f_q[k][FRAC_BITS-2:0], sq[63]};
        m_q[k+1] <= sq[63] ? sq[63:32] : sq[62:31];
      end
    end
  end

  assign ln_prod = (L_W+32)'({p_q[FRAC_BITS], f_q[FRAC_BITS]}) * (L_W+32)'(LN2_Q32)
                 + (L_W+32)'(33'h0_8000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= 1'b0;
    end else if (en_i) begin
      vl_q <= v_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zl_q <= z_q[FRAC_BITS];
      l_q  <= ln_prod[L_W+31:32];
    end
  end

  assign ctl_o = '{valid: vl_q, res_zero: zl_q};
  assign l_o   = l_q;

endmodule

// File: rtl/core/trt_poly.sv
module trt_poly import trt_pkg::*; #(
  parameter int unsigned RES_BITS = RES_BITS_DEF,
  localparam int unsigned L_W     = $clog2(RES_BITS) + FRAC_BITS,
  localparam int unsigned L2_W    = 2 * L_W - FRAC_BITS,
  localparam int unsigned L3_W    = L2_W + L_W - FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  lane_ctl_t                ctl_i,
  input  logic [L_W-1:0]           l_i,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic signed [COEF_W-1:0] coef_c_i,
  output lane_ctl_t                ctl_o,
  output logic signed [SUM_W-1:0]  s_o
);

  lane_ctl_t                      c2_q, c3_q, c4_q, c5_q;
  logic [L_W-1:0]                 l2s_q;
  logic [L2_W-1:0]                l2_q;
  logic [L3_W-1:0]                l3_q;
  logic [2*L_W-1:0]               sq_full;
  logic [L2_W+L_W-1:0]            cube_full;
  logic signed [COEF_H+L_W:0]     pb_hi_d, pb_hi_q;
  logic [COEF_H+L_W-1:0]          pb_lo_d, pb_lo_q;
  logic signed [COEF_H+L3_W:0]    pc_hi_d, pc_hi_q;
  logic [COEF_H+L3_W-1:0]         pc_lo_d, pc_lo_q;
  logic signed [SUM_W-1:0]        tb_d, tb_q, s_d, s_q;

  assign sq_full   = (2*L_W)'(l_i) * (2*L_W)'(l_i);
  assign cube_full = (L2_W+L_W)'(l2_q) * (L2_W+L_W)'(l2s_q);

  // floor(coef*x / 2^24) = hi(coef)*x + floor(lo(coef)*x / 2^24).
  assign pb_hi_d = $signed(coef_b_i[COEF_W-1:COEF_H]) * $signed({1'b0, l2s_q});
  assign pb_lo_d = (COEF_H+L_W)'(coef_b_i[COEF_H-1:0]) * (COEF_H+L_W)'(l2s_q);
  assign pc_hi_d = $signed(coef_c_i[COEF_W-1:COEF_H]) * $signed({1'b0, l3_q});
  assign pc_lo_d = (COEF_H+L3_W)'(coef_c_i[COEF_H-1:0]) * (COEF_H+L3_W)'(l3_q);

  assign tb_d = SUM_W'(pb_hi_q) + SUM_W'(pb_lo_q[COEF_H+L_W-1:FRAC_BITS]);
  assign s_d  = SUM_W'(coef_a_i) + tb_q + SUM_W'(pc_hi_q)
              + SUM_W'(pc_lo_q[COEF_H+L3_W-1:FRAC_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else if (en_i) begin
      c2_q <= ctl_i;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l2_q    <= sq_full[2*L_W-1:FRAC_BITS];
      l2s_q   <= l_i;
      l3_q    <= cube_full[L2_W+L_W-1:FRAC_BITS];
      pb_hi_q <= pb_hi_d;
      pb_lo_q <= pb_lo_d;
      pc_hi_q <= pc_hi_d;
      pc_lo_q <= pc_lo_d;
      tb_q    <= tb_d;
      s_q     <= s_d;
    end
  end

  assign ctl_o = c5_q;
  assign s_o   = s_q;

endmodule

// File: rtl/core/trt_recip.sv
module trt_recip import trt_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  lane_ctl_t               ctl_i,
  input  logic signed [SUM_W-1:0] s_i,
  input  logic [UL_W-1:0]         upper_i,
  output logic                    valid_o,
  output status_e                 status_o,
  output logic [Y_W-1:0]          y_o
);

  // Dividend 5120 * 2^F in kelvin steps of 1/5120.
  localparam logic [127:0]     NUM     = 128'd5 << (COEF_FRAC_BITS + 10);
  localparam logic [DIV_W-1:0] SAT_LIM = DIV_W'(NUM >> Q_W);

  logic             v_q   [0:Q_W];
  status_e          st_q  [0:Q_W];
  logic [DIV_W-1:0] den_q [0:Q_W];
  logic [DIV_W-1:0] rem_q [0:Q_W];
  logic [Q_W-1:0]   q_q   [0:Q_W];

  status_e          st0_d;
  logic signed [63:0] t, hi_lim, x;
  status_e          stt_d;
  logic             vt_q;
  status_e          stt_q;
  logic [Y_W-1:0]   y_q;

  // A quotient of 2^62 or more saturates, which is the case when S <= N / 2^62.
  always_comb begin
    st0_d = ST_OK;
    if (ctl_i.res_zero || s_i < 0) begin
      st0_d = ST_LOW;
    end else if (s_i == '0 || s_i[DIV_W-1:0] <= SAT_LIM) begin
      st0_d = ST_HIGH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= st0_d;
      den_q[0] <= s_i[DIV_W-1:0];
      rem_q[0] <= SAT_LIM;
      q_q[0]   <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int unsigned I = Q_W - 1 - j;
    logic [DIV_W-1:0] rem2;
    logic             ge;
    assign rem2 = {rem_q[j][DIV_W-2:0], NUM[I]};
    assign ge   = (rem2 >= den_q[j]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j+1]  <= st_q[j];
        den_q[j+1] <= den_q[j];
        rem_q[j+1] <= ge ? rem2 - den_q[j] : rem2;
        q_q[j+1]   <= {q_q[j][Q_W-2:0], ge};
      end
    end
  end

  assign t      = $signed(64'(q_q[Q_W])) - 64'sd1398528;
  assign hi_lim = $signed(64'(upper_i) * 64'(STEPS_PER_C));
  assign x      = t + 64'(LOW_LIMIT_C * STEPS_PER_C + 10);

  always_comb begin
    stt_d = st_q[Q_W];
    if (st_q[Q_W] == ST_OK) begin
      if (t > hi_lim) begin
        stt_d = ST_HIGH;
      end else if (t < -$signed(64'(LOW_LIMIT_C * STEPS_PER_C))) begin
        stt_d = ST_LOW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (en_i) begin
      vt_q <= v_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stt_q <= stt_d;
      y_q   <= x[Y_W+1:2];
    end
  end

  assign valid_o  = vt_q;
  assign status_o = stt_q;
  assign y_o      = y_q;

endmodule

// File: rtl/core/thermistor_resistance_to_temperature.sv
// Channel   Dir  Payload                          Transaction
// sample_i  in   resistance_ohms                  valid & ready
// result_o  out  temp_q8, status                  valid & ready
// cfg       in   cfg_idx_i, cfg_data_i            cfg_we_i
//
// One transaction in per cycle while the output is not stalled, one result per sample.
// The depth is set by the 24 log2 squaring stages and the 62-stage divider.
// Reset clears all valid bits and loads the default coefficients and upper limit.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module thermistor_resistance_to_temperature import trt_pkg::*; #(
  parameter int unsigned RES_BITS       = RES_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  trt_in_if.sink               sample_i,
  trt_out_if.source            result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  localparam int unsigned L_W = $clog2(RES_BITS) + FRAC_BITS;

  logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
  logic [UL_W-1:0]          upper_q;

  logic                     en;
  lane_ctl_t                log_ctl, poly_ctl;
  logic [L_W-1:0]           l;
  logic signed [SUM_W-1:0]  s;
  logic                     rc_valid;
  status_e                  rc_status;
  logic [Y_W-1:0]           rc_y;
  logic [Y_W+RECIP_W-1:0]   div_prod;
  logic signed [TEMP_W-1:0] temp_d, temp_q;
  logic                     out_v_q;
  status_e                  out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= COEF_A_RST;
      coef_b_q <= COEF_B_RST;
      coef_c_q <= COEF_C_RST;
      upper_q  <= UPPER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_A: coef_a_q <= $signed(cfg_data_i);
        CFG_COEF_B: coef_b_q <= $signed(cfg_data_i);
        CFG_COEF_C: coef_c_q <= $signed(cfg_data_i);
        CFG_UPPER:  upper_q  <= cfg_data_i[UL_W-1:0];
        default: ;
      endcase
    end
  end

  assign en             = !out_v_q || result_o.ready;
  assign sample_i.ready = en;

  trt_log #(.RES_BITS(RES_BITS)) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sample_i.valid),
    .r_i     (sample_i.resistance_ohms[RES_BITS-1:0]),
    .ctl_o   (log_ctl),
    .l_o     (l)
  );

  trt_poly #(.RES_BITS(RES_BITS)) u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (log_ctl),
    .l_i      (l),
    .coef_a_i (coef_a_q),
    .coef_b_i (coef_b_q),
    .coef_c_i (coef_c_q),
    .ctl_o    (poly_ctl),
    .s_o      (s)
  );

  trt_recip #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (poly_ctl),
    .s_i      (s),
    .upper_i  (upper_q),
    .valid_o  (rc_valid),
    .status_o (rc_status),
    .y_o      (rc_y)
  );

  // (t + 256010) / 20 as a quarter divided by five, then back to a signed offset.
  assign div_prod = (Y_W+RECIP_W)'(rc_y) * (Y_W+RECIP_W)'(DIV5_RECIP);
  assign temp_d   = (rc_status == ST_OK)
                  ? $signed(div_prod[Y_W+RECIP_W-1:DIV_SHIFT])
                    - $signed(TEMP_W'(LOW_LIMIT_C * 256))
                  : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= rc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q   <= temp_d;
      out_st_q <= rc_status;
    end
  end

  assign result_o.valid   = out_v_q;
  assign result_o.temp_q8 = temp_q;
  assign result_o.status  = out_st_q;

endmodule

// File: rtl/core/trt_checker.sv
`include "assert_macros.svh"

module trt_checker import trt_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [TEMP_W-1:0] temp,
  input logic [STAT_W-1:0]        status
);

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(temp) && $stable(status))
  `ASSERT_ALWAYS(a_in_ready, !(out_valid && !out_ready) |-> in_ready)
  `ASSERT_CLK(a_err_zero, out_valid && status != ST_OK |-> temp == '0)
  `ASSERT_CLK(a_status_code, out_valid |-> status != 2'd3)
  `ASSERT_CLK(a_temp_floor, out_valid && status == ST_OK |-> temp >= -18'sd12800)

endmodule

bind thermistor_resistance_to_temperature trt_checker u_trt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .temp      (result_o.temp_q8),
  .status    (result_o.status)
);
